FILE: hdl/lfu_pkg.sv
// Shared types and constants for the LFU replacement policy block.
// No dependencies; used by lfu_ctrl, lfu_dpath and lfu_replacement_policy.
package lfu_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_ERASE  = 2'd2;

  localparam int MODE_W     = 2;
  localparam int EXT_ID_W   = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int              LIMIT_W     = 5;
  localparam logic [4:0]      LIMIT_RESET = 5'd31;
  localparam int              CFG_ADDR_W  = 3;
  localparam logic            REG_LIMIT   = 1'b0;

  typedef enum logic [1:0] {
    SWEEP_MIN,
    SWEEP_MATCH,
    SWEEP_SHIFT
  } sweep_t;

  // Controller to datapath
  typedef struct packed {
    logic   latch_key;
    logic   append;
    logic   sweep_start;
    sweep_t sweep_kind;
    logic   touch_write;
    logic   dec_count;
    logic   load_out;
    logic   out_evict;
    logic   out_found;
    logic   out_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic over_limit;
    logic over_after;
    logic found;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/lfu_replacement_policy.sv
// Least-frequently-used replacement policy, top level.
// Unpacks the stream and APB ports; instantiates lfu_ctrl and lfu_dpath. Uses lfu_pkg.
//
// Usage: requests enter on in_* (mode on in_tuser, entry_id on in_tdata) and
// results leave on out_*. Each request yields one result, or one result per victim
// for an insert that pushes the table over capacity_limit; out_tlast marks
// the final result of a request. capacity_limit is written over the APB
// port at address 0 by the user while the block is idle; the block does not check it.
// Operation, one request at a time: a touch scans the table for the id and, on a hit,
// writes the raised count back; an erase scans the table and, on a hit, shifts the
// entries behind the erased one down; an insert that evicts nothing does no scan.
// Each eviction scans the table for the least-used entry, emits it, then shifts the
// entries behind the victim down. One slot of the table memory is read per cycle
// during each scan and each compaction step.
// Reset: the table is empty and capacity_limit is 31; no clearing pass.
// Stall: the result register holds while out_tready low;
// a new request is taken once the previous one is finished, even if its result waits.
module lfu_replacement_policy #(
  parameter int ENTRIES    = 32,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lfu_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] entry_id
  input  logic [lfu_pkg::MODE_W-1:0]        in_tuser,   // [1:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lfu_pkg::OUT_DATA_W-1:0]    out_tdata,  // [15:0] victim_id, [16] found
  output logic [0:0]                        out_tuser,  // [0] evict_valid
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lfu_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic [lfu_pkg::LIMIT_W-1:0]  limit_r;
  logic [lfu_pkg::MODE_W-1:0]   in_mode;
  logic [ID_BITS-1:0]           in_key;
  logic                         reg_hit;
  lfu_pkg::cmd_t                cmd;
  lfu_pkg::stat_t               stat;
  logic                         res_evict;
  logic [lfu_pkg::EXT_ID_W-1:0] res_id;
  logic                         res_found;

  assign in_mode = in_tuser;
  assign in_key  = ID_BITS'(in_tdata);

  assign reg_hit    = (cfg_paddr[2] == lfu_pkg::REG_LIMIT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lfu_pkg::LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      limit_r <= cfg_pwdata[lfu_pkg::LIMIT_W-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_mode),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_in    (in_key),
    .limit     (limit_r),
    .out_ready (out_tready),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_evict (res_evict),
    .out_id    (res_id),
    .out_found (res_found),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'b0, res_found, res_id};
  assign out_tuser = res_evict;

endmodule

FILE: hdl/lfu_dpath.sv
// Datapath of the LFU replacement policy: table memory, entry count,
// scan/shift sweep engine, selection registers and the result register. Uses lfu_pkg.
module lfu_dpath #(
  parameter int ENTRIES    = 32,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfu_pkg::cmd_t                 cmd,
  input  logic [ID_BITS-1:0]            key_in,
  input  logic [lfu_pkg::LIMIT_W-1:0]   limit,
  input  logic                          out_ready,
  output lfu_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic                          out_evict,
  output logic [lfu_pkg::EXT_ID_W-1:0]  out_id,
  output logic                          out_found,
  output logic                          out_last
);

  localparam int DEPTH = ENTRIES + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(ENTRIES + 2);
  localparam int WW    = ID_BITS + COUNT_BITS;
  localparam int CMPW  = (CW > lfu_pkg::LIMIT_W) ? CW : lfu_pkg::LIMIT_W;

  logic [WW-1:0]         mem_r [DEPTH];
  logic [WW-1:0]         rd_r;
  logic [IW-1:0]         ri_r;
  logic                  rv_r;
  logic                  busy_r;
  lfu_pkg::sweep_t       kind_r;
  logic [CW-1:0]         issue_r;
  logic [CW-1:0]         cnt_r;
  logic [ID_BITS-1:0]    key_r;
  logic [IW-1:0]         sel_idx_r;
  logic [ID_BITS-1:0]    sel_id_r;
  logic [COUNT_BITS-1:0] sel_cnt_r;
  logic                  found_r;

  logic                  out_valid_r;
  logic                  out_evict_r;
  logic [lfu_pkg::EXT_ID_W-1:0] out_id_r;
  logic                  out_found_r;
  logic                  out_last_r;

  logic                  issue_go;
  logic [CW-1:0]         issue_start;
  logic [CW-1:0]         cnt_m1;
  logic [ID_BITS-1:0]    rd_id;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  we;
  logic [IW-1:0]         wa;
  logic [WW-1:0]         wd;
  logic                  out_free;

  assign issue_go    = busy_r && (issue_r < cnt_r);
  assign issue_start = (cmd.sweep_kind == lfu_pkg::SWEEP_SHIFT) ?
                       (CW'(sel_idx_r) + CW'(1)) : '0;
  assign cnt_m1      = cnt_r - CW'(1);
  assign rd_id       = rd_r[WW-1:COUNT_BITS];
  assign rd_cnt      = rd_r[COUNT_BITS-1:0];
  assign cnt_inc     = (sel_cnt_r == '1) ? sel_cnt_r : (sel_cnt_r + COUNT_BITS'(1));
  assign out_free    = !out_valid_r || out_ready;

  // Write port: append, touch update or one step of the compaction shift
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd.append) begin
      we = 1'b1;
      wa = cnt_r[IW-1:0];
      wd = {key_in, COUNT_BITS'(1)};
    end else if (cmd.touch_write) begin
      we = 1'b1;
      wa = sel_idx_r;
      wd = {key_r, cnt_inc};
    end else if (rv_r && kind_r == lfu_pkg::SWEEP_SHIFT) begin
      we = 1'b1;
      wa = ri_r - IW'(1);
      wd = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (issue_go) begin
      rd_r <= mem_r[issue_r[IW-1:0]];
      ri_r <= issue_r[IW-1:0];
    end
    if (cmd.latch_key) begin
      key_r <= key_in;
    end
    if (cmd.load_out) begin
      out_evict_r <= cmd.out_evict;
      out_id_r    <= cmd.out_evict ? lfu_pkg::EXT_ID_W'(sel_id_r) : '0;
      out_found_r <= cmd.out_found;
      out_last_r  <= cmd.out_last;
    end
  end

  // Sweep engine: one read issued per cycle; the read data is registered, then compared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rv_r      <= 1'b0;
      kind_r    <= lfu_pkg::SWEEP_MIN;
      issue_r   <= '0;
      found_r   <= 1'b0;
      sel_idx_r <= '0;
      sel_id_r  <= '0;
      sel_cnt_r <= '0;
    end else begin
      if (cmd.sweep_start) begin
        busy_r  <= 1'b1;
        rv_r    <= 1'b0;
        kind_r  <= cmd.sweep_kind;
        issue_r <= issue_start;
        if (cmd.sweep_kind == lfu_pkg::SWEEP_MATCH) begin
          found_r <= 1'b0;
        end
      end else if (busy_r) begin
        rv_r <= issue_go;
        if (issue_go) begin
          issue_r <= issue_r + CW'(1);
        end
        if (!issue_go && !rv_r) begin
          busy_r <= 1'b0;
        end
      end
      if (rv_r) begin
        case (kind_r)
          lfu_pkg::SWEEP_MIN: begin
            // strict compare keeps the oldest slot on a tie
            if (ri_r == '0 || rd_cnt < sel_cnt_r) begin
              sel_idx_r <= ri_r;
              sel_id_r  <= rd_id;
              sel_cnt_r <= rd_cnt;
            end
          end
          lfu_pkg::SWEEP_MATCH: begin
            if (!found_r && rd_id == key_r) begin
              found_r   <= 1'b1;
              sel_idx_r <= ri_r;
              sel_id_r  <= rd_id;
              sel_cnt_r <= rd_cnt;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.append) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.dec_count) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Effective limit is min(limit, ENTRIES)
  assign stat.busy       = busy_r;
  assign stat.over_limit = (CMPW'(cnt_r) > CMPW'(limit)) || (cnt_r > CW'(ENTRIES));
  assign stat.over_after = (CMPW'(cnt_m1) > CMPW'(limit)) || (cnt_m1 > CW'(ENTRIES));
  assign stat.found      = found_r;
  assign stat.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_evict = out_evict_r;
  assign out_id    = out_id_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

endmodule

FILE: hdl/lfu_ctrl.sv
// Controller state machine of the LFU replacement policy.
// Sequences insert/evict, touch and erase through lfu_dpath; uses lfu_pkg.
module lfu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [lfu_pkg::MODE_W-1:0]  in_mode,
  output logic                        in_ready,
  input  lfu_pkg::stat_t              stat,
  output lfu_pkg::cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MIN_WAIT,
    S_EVICT,
    S_SHIFT_WAIT,
    S_MATCH_WAIT,
    S_REPLY
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lfu_pkg::MODE_W-1:0]  op_r, op_nxt;
  logic                        evicted_r, evicted_nxt;
  logic                        is_lookup;

  assign in_ready  = (state_r == S_IDLE);
  assign is_lookup = op_r inside {lfu_pkg::MODE_TOUCH, lfu_pkg::MODE_ERASE};

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    evicted_nxt = evicted_r;
    cmd         = '0;
    cmd.sweep_kind = lfu_pkg::SWEEP_MIN;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_mode;
          evicted_nxt   = 1'b0;
          cmd.latch_key = 1'b1;
          case (in_mode)
            lfu_pkg::MODE_INSERT: begin
              cmd.append = 1'b1;
              state_nxt  = S_CHECK;
            end
            lfu_pkg::MODE_TOUCH, lfu_pkg::MODE_ERASE: begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_kind  = lfu_pkg::SWEEP_MATCH;
              state_nxt       = S_MATCH_WAIT;
            end
            default: begin
              state_nxt = S_REPLY;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (stat.over_limit) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_kind  = lfu_pkg::SWEEP_MIN;
          state_nxt       = S_MIN_WAIT;
        end else if (!evicted_r) begin
          state_nxt = S_REPLY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MIN_WAIT: begin
        if (!stat.busy) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        // emit the victim, then close the gap it leaves
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_evict   = 1'b1;
          cmd.out_last    = !stat.over_after;
          cmd.sweep_start = 1'b1;
          cmd.sweep_kind  = lfu_pkg::SWEEP_SHIFT;
          evicted_nxt     = 1'b1;
          state_nxt       = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        if (!stat.busy) begin
          cmd.dec_count = 1'b1;
          state_nxt     = (op_r == lfu_pkg::MODE_INSERT) ? S_CHECK : S_REPLY;
        end
      end
      S_MATCH_WAIT: begin
        if (!stat.busy) begin
          if (stat.found && op_r == lfu_pkg::MODE_TOUCH) begin
            cmd.touch_write = 1'b1;
            state_nxt       = S_REPLY;
          end else if (stat.found) begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_kind  = lfu_pkg::SWEEP_SHIFT;
            state_nxt       = S_SHIFT_WAIT;
          end else begin
            state_nxt = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_found = is_lookup && stat.found;
          cmd.out_last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= lfu_pkg::MODE_INSERT;
      evicted_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      evicted_r <= evicted_nxt;
    end
  end

endmodule

FILE: tb/sv/lfu_replacement_policy_tb.sv
// Self-checking testbench for lfu_replacement_policy: directed and random requests on the
// stream port, capacity_limit writes over APB, every result checked against a local LFU table.
// Depends on lfu_pkg and the lfu_replacement_policy RTL.
`timescale 1ns / 1ps

module lfu_replacement_policy_tb;

  localparam int         ENTRIES        = 32;
  localparam int         CFG_AW         = lfu_pkg::CFG_ADDR_W;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'(4 * int'(lfu_pkg::REG_LIMIT));
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         TAIL_CYCLES    = 100;
  localparam int         DRAIN_EVERY    = 40;

  typedef struct packed {
    logic        evict;
    logic [15:0] victim;
    logic        found;
    logic        last;
  } lfu_result_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [lfu_pkg::IN_DATA_W-1:0]   in_tdata    = '0;   // [15:0] entry_id
  logic [lfu_pkg::MODE_W-1:0]      in_tuser    = '0;   // [1:0] mode
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [lfu_pkg::OUT_DATA_W-1:0]  out_tdata;          // [15:0] victim_id, [16] found
  logic [0:0]                      out_tuser;          // [0] evict_valid
  logic                            out_tlast;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]               cfg_paddr   = '0;
  logic [31:0]                     cfg_pwdata  = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  // Local copy of the policy table
  logic [15:0]  tbl_ids    [0:ENTRIES];
  logic [31:0]  tbl_counts [0:ENTRIES];
  int           tbl_used  = 0;
  logic [4:0]   limit_reg = lfu_pkg::LIMIT_RESET;

  lfu_result_t  pending_results[$];
  lfu_result_t  obs_result;
  lfu_result_t  exp_result;
  int           errors      = 0;
  int           idle_cycles = 0;
  int           rx_hold     = 0;
  bit           rx_steady   = 1'b0;
  bit           in_steady   = 1'b0;
  bit           in_busy     = 1'b0;

  lfu_replacement_policy u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic string fmt_result(input lfu_result_t r);
    return $sformatf("evict %0b victim %h found %0b last %0b",
                     r.evict, r.victim, r.found, r.last);
  endfunction

  // Append one expected result at the tail of the queue
  task automatic queue_result(input lfu_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic remove_slot(input int pos);
    for (int i = pos; i + 1 < tbl_used; i++) begin
      tbl_ids[i]    = tbl_ids[i + 1];
      tbl_counts[i] = tbl_counts[i + 1];
    end
    tbl_used--;
  endtask

  // Apply one accepted request to the table and queue the results it causes
  task automatic compute_lfu_results(input logic [1:0] mode, input logic [15:0] id);
    int          lim;
    int          pos;
    int          worst;
    int          n;
    lfu_result_t r;
    n   = 0;
    pos = -1;
    case (mode)
      lfu_pkg::MODE_INSERT: begin
        lim = (int'(limit_reg) > ENTRIES) ? ENTRIES : int'(limit_reg);
        tbl_ids[tbl_used]    = id;
        tbl_counts[tbl_used] = 32'd1;
        tbl_used++;
        while (tbl_used > lim && tbl_used > 0) begin
          worst = 0;
          for (int i = 1; i < tbl_used; i++) begin
            if (tbl_counts[i] < tbl_counts[worst]) worst = i;
          end
          r = '{1'b1, tbl_ids[worst], 1'b0, 1'b0};
          n++;
          remove_slot(worst);
          r.last = (tbl_used > lim && tbl_used > 0) ? 1'b0 : 1'b1;
          queue_result(r);
        end
        if (n == 0) begin
          queue_result('{1'b0, 16'h0000, 1'b0, 1'b1});
        end
      end
      lfu_pkg::MODE_TOUCH, lfu_pkg::MODE_ERASE: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (pos < 0 && tbl_ids[i] == id) pos = i;
        end
        if (pos >= 0) begin
          if (mode == lfu_pkg::MODE_TOUCH) begin
            if (tbl_counts[pos] != 32'hFFFF_FFFF) tbl_counts[pos] = tbl_counts[pos] + 32'd1;
          end else begin
            remove_slot(pos);
          end
        end
        queue_result('{1'b0, 16'h0000, pos >= 0, 1'b1});
      end
      default: begin
        queue_result('{1'b0, 16'h0000, 1'b0, 1'b1});
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] mode, input logic [15:0] id);
    int gap;
    gap = in_steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    if (gap > 0) begin
      if (in_busy) in_tvalid <= 1'b0;
      in_busy = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= mode;
    in_busy    = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compute_lfu_results(mode, id);
  endtask

  // Drop the request line and hold until every queued result has come back
  // and the block is idle again
  task automatic wait_results_done();
    if (in_busy) in_tvalid <= 1'b0;
    in_busy = 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || !in_tready) @(posedge clk);
  endtask

  task automatic write_capacity_limit(input logic [4:0] value);
    wait_results_done();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LIMIT_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    limit_reg = value;
    // read back: go straight to the read setup phase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== 32'(value))
      report_mismatch($sformatf("capacity_limit read %h, wrote %h", cfg_prdata, value));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_random_request(input int insert_pct, output bit counted);
    int          pick;
    logic [1:0]  mode;
    logic [15:0] id;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 3) begin
      mode    = MODE_UNUSED;
      counted = 1'b0;
    end else if (pick < 3 + insert_pct) begin
      mode = lfu_pkg::MODE_INSERT;
    end else if (pick < 3 + insert_pct + (97 - insert_pct) * 2 / 3) begin
      mode = lfu_pkg::MODE_TOUCH;
    end else begin
      mode = lfu_pkg::MODE_ERASE;
    end
    id = 16'($urandom_range(0, 65535));
    if (tbl_used > 0) begin
      // mostly hit stored ids; now and then insert a duplicate
      if (mode != lfu_pkg::MODE_INSERT && $urandom_range(0, 9) < 7)
        id = tbl_ids[$urandom_range(0, tbl_used - 1)];
      else if (mode == lfu_pkg::MODE_INSERT && $urandom_range(0, 19) == 0)
        id = tbl_ids[$urandom_range(0, tbl_used - 1)];
    end
    send_request(mode, id);
  endtask

  task automatic run_random(input int n_items, input int insert_pct);
    int done;
    bit counted;
    done = 0;
    while (done < n_items) begin
      send_random_request(insert_pct, counted);
      if (counted) done++;
      if (counted && done % DRAIN_EVERY == 0) wait_results_done();
    end
  endtask

  task automatic fill_table(input int target);
    while (tbl_used < target)
      send_request(lfu_pkg::MODE_INSERT, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_basic_operations();
    send_request(lfu_pkg::MODE_INSERT, 16'h0000);
    send_request(lfu_pkg::MODE_INSERT, 16'hFFFF);
    send_request(lfu_pkg::MODE_TOUCH,  16'hFFFF);
    send_request(lfu_pkg::MODE_TOUCH,  16'h1234);   // miss
    send_request(lfu_pkg::MODE_ERASE,  16'h0000);
    send_request(lfu_pkg::MODE_ERASE,  16'h0000);   // miss
    send_request(MODE_UNUSED,          16'hFFFF);
    send_request(lfu_pkg::MODE_INSERT, 16'hFFFF);   // duplicate id
    send_request(lfu_pkg::MODE_TOUCH,  16'hFFFF);   // hits the oldest copy
    send_request(lfu_pkg::MODE_ERASE,  16'hFFFF);
    send_request(lfu_pkg::MODE_ERASE,  16'hFFFF);
  endtask

  task automatic test_eviction_order();
    write_capacity_limit(5'd0);
    send_request(lfu_pkg::MODE_INSERT, 16'hA5A5);   // evicts itself
    send_request(lfu_pkg::MODE_INSERT, 16'h5A5A);
    write_capacity_limit(5'd2);
    send_request(lfu_pkg::MODE_INSERT, 16'h0001);
    send_request(lfu_pkg::MODE_INSERT, 16'h0002);
    send_request(lfu_pkg::MODE_TOUCH,  16'h0001);
    send_request(lfu_pkg::MODE_INSERT, 16'h0003);   // tie on count 1, oldest goes
    send_request(lfu_pkg::MODE_TOUCH,  16'h0003);
    send_request(lfu_pkg::MODE_INSERT, 16'h0004);   // new entry is the only count-1 slot
  endtask

  task automatic test_full_table_random();
    write_capacity_limit(5'd31);
    fill_table(31);
    run_random(120, 45);
  endtask

  task automatic test_max_evictions();
    fill_table(31);
    write_capacity_limit(5'd0);
    send_request(lfu_pkg::MODE_INSERT, 16'($urandom_range(0, 65535)));
    run_random(30, 50);
  endtask

  task automatic test_random_limits();
    repeat (4) begin
      write_capacity_limit(5'($urandom_range(1, 30)));
      run_random(25, 45);
    end
    write_capacity_limit(5'd1);
    run_random(40, 40);
  endtask

  task automatic test_back_to_back();
    write_capacity_limit(5'd8);
    in_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(60, 45);
    wait_results_done();
    in_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side: random stalls after each result and at idle times, unless rx_steady is set
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold     = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        rx_hold = rx_steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      else if (rx_hold > 0)
        rx_hold--;
      else if (!rx_steady && $urandom_range(0, 7) == 0)
        rx_hold = $urandom_range(1, 12);
      out_tready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      obs_result = {out_tuser[0], out_tdata[15:0], out_tdata[16], out_tlast};
      if (pending_results.size() == 0) begin
        report_mismatch({"unexpected result: ", fmt_result(obs_result)});
      end else begin
        exp_result = pending_results.pop_front();
        if (obs_result !== exp_result)
          report_mismatch({"got ", fmt_result(obs_result), ", want ", fmt_result(exp_result)});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("lfu_replacement_policy_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_operations();
    test_eviction_order();
    test_full_table_random();
    test_max_evictions();
    test_random_limits();
    test_back_to_back();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("lfu_replacement_policy_tb passed");
    end else begin
      $display("lfu_replacement_policy_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lfu_pkg.sv
hdl/lfu_dpath.sv
hdl/lfu_ctrl.sv
hdl/lfu_replacement_policy.sv
tb/sv/lfu_replacement_policy_tb.sv
